/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define MTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// check on every clock edge, reset included
`define MTC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

/* hw/rtl/mtc_pkg.sv */
`default_nettype none
package mtc_pkg;

	localparam int TICK_WIDTH_DEF = 32;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [29:0] NS_MAX     = 30'd999999999;
	localparam logic [31:0] NS_TWO_SEC = 32'd2000000000;
	localparam logic [18:0] NS_RECIP   = 19'd281474;

	localparam logic [16:0] TICK_RATE_RST   = 17'd100;
	localparam logic [29:0] NS_PER_TICK_RST = 30'd10000000;
	localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd6;

	localparam logic [1:0] FUNC_READ = 2'd0;
	localparam logic [1:0] FUNC_SYNC = 2'd1;
	localparam logic [1:0] FUNC_FAIL = 2'd2;

	localparam logic [1:0] REG_TICK_RATE   = 2'd0;
	localparam logic [1:0] REG_NS_PER_TICK = 2'd1;
	localparam logic [1:0] REG_FAIL_LIMIT  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] tick_now;
		logic [31:0] ref_seconds;
		logic [29:0] ref_nanoseconds;
	} in_word_t;

	typedef struct packed {
		logic        time_valid;
		logic [31:0] out_seconds;
		logic [29:0] out_nanoseconds;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic rd_div_go;
		logic rd_mul;
		logic ns_load;
		logic sy_load;
		logic cd_est;
		logic cd_back;
		logic cd_fix;
		logic rd_upd;
		logic sy_mul1;
		logic sy_mul2;
		logic sy_upd;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       rd_hold;
		logic       sync_later;
		logic       div_done;
	} dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/mtc_div.sv */
`default_nettype none
module mtc_div #(
	parameter int DIV_W = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [29:0]      divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quot,
	output logic      [29:0]      rem
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] q_q;
	logic [29:0]      r_q;
	logic [29:0]      d_q;
	logic [30:0]      shifted;
	logic [30:0]      diff;
	logic             take;

	assign shifted = {r_q, q_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign take    = shifted >= {1'b0, d_q};
	assign done    = busy_q && (cnt_q == CNT_W'(1));
	assign quot    = q_q;
	assign rem     = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_W-2:0], take};
			r_q <= take ? diff[29:0] : shifted[29:0];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/mtc_dpath.sv */
`default_nettype none
module mtc_dpath import mtc_pkg::*; #(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_word_t    in_word,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [29:0] cfg_data,
	input  wire ctrl_cmd_t   cmd,
	output dp_status_t       status,
	output out_word_t        out_word
);

	localparam int NW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

	logic [16:0]           tick_rate_q;
	logic [29:0]           ns_per_tick_q;
	logic [7:0]            fail_limit_q;

	logic [31:0]           clock_s_q;
	logic [29:0]           clock_ns_q;
	logic [TICK_WIDTH-1:0] last_tick_q;
	logic [31:0]           skip_q;
	logic                  synced_q;
	logic [7:0]            fail_q;

	logic [1:0]            func_q;
	logic [TICK_WIDTH-1:0] now_q;
	logic [31:0]           rs_q;
	logic [29:0]           rns_q;

	logic [NW-1:0]         nticks_q;
	logic [31:0]           q1_q;
	logic [31:0]           dsec_q;
	logic [29:0]           dns_q;
	logic [61:0]           prod_q;
	logic [48:0]           p1_q;
	logic [47:0]           cx_q;
	logic [18:0]           cest_q;
	logic [31:0]           cr_q;
	logic [18:0]           cquot_q;
	logic [29:0]           crem_q;
	out_word_t             out_q;

	logic [16:0]           rate_eff;
	logic [TICK_WIDTH-1:0] nticks_raw;
	logic [NW-1:0]         nt_ext;
	logic [NW-1:0]         skip_ext;
	logic                  rd_hold;
	logic                  sync_later;
	logic                  borrow;
	logic [7:0]            fail_next;
	logic [31:0]           mul_a;
	logic [29:0]           mul_b;
	logic                  div_start;
	logic [NW-1:0]         div_dividend;
	logic [29:0]           div_divisor;
	logic                  div_done;
	logic [NW-1:0]         div_quot;
	logic [29:0]           div_rem;
	logic [49:0]           skip_sum;
	logic [30:0]           dns_wrap;
	logic [48:0]           est_prod;
	logic [31:0]           back_prod;
	logic [18:0]           fix_quot;
	logic [29:0]           fix_rem;

	assign rate_eff   = (tick_rate_q == '0) ? 17'd1 : tick_rate_q;
	assign nticks_raw = now_q - last_tick_q;
	assign nt_ext     = NW'(nticks_raw);
	assign skip_ext   = NW'(skip_q);
	assign rd_hold    = !synced_q || (now_q == last_tick_q) || (nt_ext < skip_ext);
	assign sync_later = (rs_q > clock_s_q) || ((rs_q == clock_s_q) && (rns_q >= clock_ns_q));
	assign borrow     = clock_ns_q < rns_q;
	assign dns_wrap   = 31'(clock_ns_q) + 31'(NS_PER_SEC) - 31'(rns_q);
	assign fail_next  = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;

	always_comb begin
		mul_a = 32'(div_rem);
		mul_b = ns_per_tick_q;
		if (cmd.sy_mul1) begin
			mul_a = dsec_q;
			mul_b = 30'(rate_eff);
		end else if (cmd.sy_mul2) begin
			mul_a = 32'(dns_q);
			mul_b = 30'(rate_eff);
		end
	end

	assign div_dividend = nticks_q;
	assign div_divisor  = 30'(rate_eff);
	assign div_start    = cmd.rd_div_go;
	assign skip_sum     = 50'(p1_q) + 50'(cquot_q);

	assign est_prod  = 49'(cx_q[47:18]) * 49'(NS_RECIP);
	assign back_prod = 32'(cest_q) * 32'(NS_PER_SEC);

	always_comb begin
		if (cr_q >= NS_TWO_SEC) begin
			fix_quot = cest_q + 19'd2;
			fix_rem  = 30'(cr_q - NS_TWO_SEC);
		end else if (cr_q >= 32'(NS_PER_SEC)) begin
			fix_quot = cest_q + 19'd1;
			fix_rem  = 30'(cr_q - 32'(NS_PER_SEC));
		end else begin
			fix_quot = cest_q;
			fix_rem  = cr_q[29:0];
		end
	end

	mtc_div #(
		.DIV_W(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q   <= TICK_RATE_RST;
			ns_per_tick_q <= NS_PER_TICK_RST;
			fail_limit_q  <= FAIL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_RATE:   tick_rate_q   <= cfg_data[16:0];
				REG_NS_PER_TICK: ns_per_tick_q <= cfg_data;
				REG_FAIL_LIMIT:  fail_limit_q  <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_s_q   <= '0;
			clock_ns_q  <= '0;
			last_tick_q <= '0;
			skip_q      <= '0;
			synced_q    <= 1'b0;
			fail_q      <= '0;
		end else if (cmd.eval) begin
			case (func_q)
				FUNC_READ: begin
					if (!rd_hold) begin
						skip_q      <= '0;
						last_tick_q <= now_q;
					end
				end
				FUNC_SYNC: begin
					if (sync_later) begin
						clock_s_q  <= rs_q;
						clock_ns_q <= rns_q;
						skip_q     <= '0;
					end
					last_tick_q <= now_q;
					synced_q    <= 1'b1;
					fail_q      <= '0;
				end
				FUNC_FAIL: begin
					fail_q <= fail_next;
					if (fail_next >= fail_limit_q) begin
						synced_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end else if (cmd.rd_upd) begin
			clock_ns_q <= crem_q;
			clock_s_q  <= clock_s_q + q1_q + 32'(cquot_q);
		end else if (cmd.sy_upd) begin
			skip_q <= (skip_sum > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : skip_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_word.func;
			now_q  <= TICK_WIDTH'(in_word.tick_now);
			rs_q   <= in_word.ref_seconds;
			rns_q  <= (in_word.ref_nanoseconds >= NS_PER_SEC) ? NS_MAX : in_word.ref_nanoseconds;
		end
		if (cmd.eval) begin
			nticks_q <= nt_ext - skip_ext;
			dsec_q   <= clock_s_q - rs_q - 32'(borrow);
			dns_q    <= borrow ? dns_wrap[29:0] : clock_ns_q - rns_q;
		end
		if (cmd.rd_mul) begin
			q1_q <= div_quot[31:0];
		end
		if (cmd.rd_mul || cmd.sy_mul1 || cmd.sy_mul2) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.sy_mul2) begin
			p1_q <= prod_q[48:0];
		end
		if (cmd.ns_load) begin
			cx_q <= prod_q[47:0] + 48'(clock_ns_q);
		end else if (cmd.sy_load) begin
			cx_q <= prod_q[47:0];
		end
		if (cmd.cd_est) begin
			cest_q <= est_prod[48:30];
		end
		if (cmd.cd_back) begin
			cr_q <= cx_q[31:0] - back_prod;
		end
		if (cmd.cd_fix) begin
			cquot_q <= fix_quot;
			crem_q  <= fix_rem;
		end
		if (cmd.load_out) begin
			out_q.time_valid      <= synced_q;
			out_q.out_seconds     <= synced_q ? clock_s_q : '0;
			out_q.out_nanoseconds <= synced_q ? clock_ns_q : '0;
		end
	end

	assign status.func       = func_q;
	assign status.rd_hold    = rd_hold;
	assign status.sync_later = sync_later;
	assign status.div_done   = div_done;
	assign out_word          = out_q;

endmodule
`default_nettype wire

/* hw/rtl/mtc_ctrl.sv */
`default_nettype none
module mtc_ctrl import mtc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EVAL  = 4'd1;
	localparam logic [3:0] S_RDIV  = 4'd2;
	localparam logic [3:0] S_RWAIT = 4'd3;
	localparam logic [3:0] S_RMUL  = 4'd4;
	localparam logic [3:0] S_NLOAD = 4'd5;
	localparam logic [3:0] S_SMUL1 = 4'd6;
	localparam logic [3:0] S_SMUL2 = 4'd7;
	localparam logic [3:0] S_SLOAD = 4'd8;
	localparam logic [3:0] S_CEST  = 4'd9;
	localparam logic [3:0] S_CBACK = 4'd10;
	localparam logic [3:0] S_CFIX  = 4'd11;
	localparam logic [3:0] S_RUPD  = 4'd12;
	localparam logic [3:0] S_SUPD  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_EVAL;
			S_EVAL: begin
				if (status.func == FUNC_READ && !status.rd_hold) begin
					state_d = S_RDIV;
				end else if (status.func == FUNC_SYNC && !status.sync_later) begin
					state_d = S_SMUL1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RDIV:  state_d = S_RWAIT;
			S_RWAIT: if (status.div_done) state_d = S_RMUL;
			S_RMUL:  state_d = S_NLOAD;
			S_NLOAD: state_d = S_CEST;
			S_SMUL1: state_d = S_SMUL2;
			S_SMUL2: state_d = S_SLOAD;
			S_SLOAD: state_d = S_CEST;
			S_CEST:  state_d = S_CBACK;
			S_CBACK: state_d = S_CFIX;
			S_CFIX:  state_d = (status.func == FUNC_READ) ? S_RUPD : S_SUPD;
			S_RUPD:  state_d = S_DONE;
			S_SUPD:  state_d = S_DONE;
			S_DONE:  if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.eval      = (state_q == S_EVAL);
		cmd.rd_div_go = (state_q == S_RDIV);
		cmd.rd_mul    = (state_q == S_RMUL);
		cmd.ns_load   = (state_q == S_NLOAD);
		cmd.sy_load   = (state_q == S_SLOAD);
		cmd.cd_est    = (state_q == S_CEST);
		cmd.cd_back   = (state_q == S_CBACK);
		cmd.cd_fix    = (state_q == S_CFIX);
		cmd.rd_upd    = (state_q == S_RUPD);
		cmd.sy_mul1   = (state_q == S_SMUL1);
		cmd.sy_mul2   = (state_q == S_SMUL2);
		cmd.sy_upd    = (state_q == S_SUPD);
		cmd.load_out  = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/monotonic_tick_time_of_day_clock.sv */
// One word in, one word out, one word in flight at a time. A read that advances the clock
// divides by the tick rate one quotient bit per cycle, NW = max(TICK_WIDTH, 32) bits in all;
// the split by one second takes three steps. A sync behind the clock also goes through the
// split; any other word goes straight to its result. The next word can be accepted in the
// cycle after the result is loaded, while the result waits in its register.
// Reset (arst_n low) clears time, tick, skip, sync status and fail count, and restores
// the configuration registers to their defaults.
`default_nettype none
module monotonic_tick_time_of_day_clock import mtc_pkg::*; #(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_word_t    in_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_word_t        out_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [29:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	mtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mtc_dpath #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

/* hw/rtl/mtc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module mtc_checker import mtc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire in_word_t    in_word,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire out_word_t   out_word,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [29:0] cfg_data
);

	`MTC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid)
	`MTC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word))
	`MTC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
	`MTC_ASSERT(a_invalid_zero, out_valid && !out_word.time_valid |-> out_word[61:0] == 62'd0)
	`MTC_ASSERT(a_ns_range, out_valid |-> out_word.out_nanoseconds < NS_PER_SEC)

endmodule

bind monotonic_tick_time_of_day_clock mtc_checker u_chk (.*);
`default_nettype wire
